// File: hw/rtl/bew_pkg.sv
// types and constants shared by the binary erosion window block
package bew_pkg;

    localparam logic [7:0] OBJECT_VALUE = 8'd255;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

    typedef struct packed {
        logic [7:0] pixel;
        logic       drain;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0] eroded;
        logic       frame_end;
    } result_beat_t;

endpackage

// File: hw/rtl/binary_erosion_window.sv
// binary erosion window: line memory, window register and two-entry result queue
// a result beat passes the window stage registers and then the result queue before it is valid
// throughput: one beat per cycle while pix_stall is low; the line memory read-modify-write
// keeps that pace (a write-to-read forward covers back-to-back hits on one column)
// the first result of a frame comes with input beat r*width+r
// reset: registers to defaults, counters and result queue cleared, line memory untouched
module binary_erosion_window #(
    parameter int MAX_RADIUS = 2,
    parameter int MAX_WIDTH  = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  bew_pkg::pixel_beat_t pix,
    output logic                 res_valid,
    input  logic                 res_stall,
    output bew_pkg::result_beat_t res
);

    import bew_pkg::*;

    localparam int TAPS = 2 * MAX_RADIUS + 1;
    localparam int HIST = 2 * MAX_RADIUS;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RB   = $clog2(MAX_RADIUS + 1);
    localparam int LW   = $clog2(MAX_RADIUS * (MAX_WIDTH + 1) + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT);

    // configuration registers
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [1:0]  window_radius_reg;
    logic        cfg_write;
    logic        cfg_restart;
    logic [1:0]  cfg_index;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [RB-1:0] r_eff;
    logic [LW-1:0] lag;

    // frame counters
    logic [LW-1:0] pos_reg, pos_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [CW-1:0] ocol_reg, ocol_next;
    logic [RW-1:0] orow_reg, orow_next;

    logic pix_accept;
    logic acc_has;
    logic acc_last;
    logic acc_inside;
    logic acc_obj;

    // window stage
    logic            s1_valid_reg;
    logic            s1_obj_reg;
    logic            s1_has_reg;
    logic            s1_last_reg;
    logic            s1_inside_reg;
    logic [CW-1:0]   s1_addr_reg;
    logic            fwd_hit_reg;
    logic [HIST-1:0] fwd_data_reg;
    logic [HIST-1:0] mem_rdata_reg;
    logic [HIST-1:0] line_mem [MAX_WIDTH];
    logic [HIST-1:0] s1_lines;
    logic [TAPS-1:0] cur_col;
    logic [HIST-1:0] wb_data;
    logic [TAPS-1:0] win_reg [HIST];
    logic [TAPS-1:0] win_cols [TAPS];
    logic            all_set;
    result_beat_t    s1_result;

    // result queue
    result_beat_t res_fifo_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg, count_next;
    logic         push;
    logic         pop;
    logic [2:0]   fill_after;

    // configuration port
    assign pready      = 1'b1;
    assign cfg_index   = paddr[3:2];
    assign cfg_write   = psel && penable && pwrite;
    assign cfg_restart = cfg_write && (cfg_index inside
                         {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_RADIUS});

    always_comb
    begin
        unique case (cfg_index)
            REG_IMAGE_WIDTH:   prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = 32'(image_height_reg);
            REG_WINDOW_RADIUS: prdata = 32'(window_radius_reg);
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 11'd640;
            image_height_reg  <= 13'd480;
            window_radius_reg <= 2'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[10:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[12:0];
                REG_WINDOW_RADIUS: window_radius_reg <= pwdata[1:0];
                default:           ;
            endcase
        end
    end

    // saturated working values
    always_comb
    begin
        if (image_width_reg == 11'd0)
            w_eff = WW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width_reg);

        if (image_height_reg == 13'd0)
            h_eff = HW'(1);
        else if (32'(image_height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(image_height_reg);

        if (32'(window_radius_reg) > MAX_RADIUS)
            r_eff = RB'(MAX_RADIUS);
        else
            r_eff = RB'(window_radius_reg);

        lag = LW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    end

    // input side: position bookkeeping
    assign pix_accept = pix_valid && !pix_stall;
    assign acc_obj    = !pix.drain && (pix.pixel == OBJECT_VALUE);
    assign acc_has    = (pos_reg >= lag);
    assign acc_last   = acc_has && (32'(orow_reg) == 32'(h_eff) - 1)
                        && (32'(ocol_reg) == 32'(w_eff) - 1);
    assign acc_inside = (32'(orow_reg) >= 32'(r_eff))
                        && (32'(orow_reg) + 32'(r_eff) < 32'(h_eff))
                        && (32'(ocol_reg) >= 32'(r_eff))
                        && (32'(ocol_reg) + 32'(r_eff) < 32'(w_eff));

    always_comb
    begin
        pos_next    = pos_reg;
        in_col_next = in_col_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (cfg_restart)
        begin
            pos_next    = '0;
            in_col_next = '0;
            ocol_next   = '0;
            orow_next   = '0;
        end
        else if (pix_accept)
        begin
            if (acc_last)
            begin
                pos_next    = '0;
                in_col_next = '0;
                ocol_next   = '0;
                orow_next   = '0;
            end
            else
            begin
                if (WW'(in_col_reg) + WW'(1) >= w_eff)
                    in_col_next = '0;
                else
                    in_col_next = in_col_reg + CW'(1);

                if (!acc_has)
                    pos_next = pos_reg + LW'(1);
                else if (WW'(ocol_reg) + WW'(1) >= w_eff)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + RW'(1);
                end
                else
                    ocol_next = ocol_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            in_col_reg <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            in_col_reg <= in_col_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    // line memory: one entry per column, bits of the rows above
    always_ff @(posedge clk)
    begin
        if (pix_accept)
            mem_rdata_reg <= line_mem[in_col_reg];
        if (s1_valid_reg)
            line_mem[s1_addr_reg] <= wb_data;
    end

    assign s1_lines = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;
    assign cur_col  = {s1_lines, s1_obj_reg};
    assign wb_data  = cur_col[HIST-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= pix_accept;
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_obj_reg    <= acc_obj;
            s1_has_reg    <= acc_has;
            s1_last_reg   <= acc_last;
            s1_inside_reg <= acc_inside;
            s1_addr_reg   <= in_col_reg;
            fwd_hit_reg   <= s1_valid_reg && (s1_addr_reg == in_col_reg);
            fwd_data_reg  <= wb_data;
        end
    end

    // window columns, newest first
    always_comb
    begin
        win_cols[0] = cur_col;
        for (int k = 1; k < TAPS; k++)
            win_cols[k] = win_reg[k-1];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_reg[0] <= cur_col;
            for (int k = 1; k < HIST; k++)
                win_reg[k] <= win_reg[k-1];
        end
    end

    always_comb
    begin
        all_set = 1'b1;
        for (int k = 0; k < TAPS; k++)
            for (int j = 0; j < TAPS; j++)
                if (k <= 2 * 32'(r_eff) && j <= 2 * 32'(r_eff) && !win_cols[k][j])
                    all_set = 1'b0;
    end

    always_comb
    begin
        s1_result.eroded    = (s1_inside_reg && all_set) ? OBJECT_VALUE : 8'd0;
        s1_result.frame_end = s1_last_reg;
    end

    // result queue
    assign push       = s1_valid_reg && s1_has_reg;
    assign res_valid  = (count_reg != 2'd0);
    assign pop        = res_valid && !res_stall;
    assign res        = res_fifo_reg[rd_ptr_reg];
    assign fill_after = 3'(count_reg) + 3'(push) - 3'(pop);
    assign pix_stall  = (fill_after >= 3'd2);
    assign count_next = 2'(fill_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            res_fifo_reg[wr_ptr_reg] <= s1_result;
    end

    // checks
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < 2'd2))
        else $error("result queue overrun");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && acc_last) |=> (pos_reg == '0 && in_col_reg == '0
                                      && ocol_reg == '0 && orow_reg == '0))
        else $error("frame counters not restarted after last position");

    a_forward_match: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_hit_reg) |-> ($past(s1_valid_reg)
                                          && s1_addr_reg == $past(s1_addr_reg)))
        else $error("forward taken without a write to the same column");

endmodule
